// ===== hdl/unique_name_fifo_defines.svh =====
// ----------------------------------------------------------------------------
// unique_name_fifo_defines
// Assertion macros shared by the name queue RTL.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_NAME_FIFO_DEFINES_SVH
`define UNIQUE_NAME_FIFO_DEFINES_SVH

// same-cycle implication, checked out of reset
`define UNF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define UNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/unf_pkg.sv =====
// ----------------------------------------------------------------------------
// unf_pkg
// Constants, codes and transfer types of the deduplicating name queue.
// ----------------------------------------------------------------------------
package unf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NAME_BYTES  = 8;
  localparam int NAME_W      = 64;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [NAME_W-1:0] name_in;
  } unf_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [NAME_W-1:0] name_out;
    logic [CNT_W-1:0]  occupancy;
  } unf_rsp_t;

endpackage

// ===== hdl/unique_name_fifo.sv =====
// ----------------------------------------------------------------------------
// unique_name_fifo
// Circular queue of names that refuses duplicates, with enqueue, dequeue
// and peek commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers at a rising edge with start high and busy low; req_i
//   carries the opcode and the name. Exactly one result follows, shown on
//   rsp_o for one cycle while done_o is high. The receiver cannot stall it.
//   Enqueue reads the queued names from the RAM one per cycle, starting at
//   the head, and compares each against the new name; the result comes when
//   a duplicate is found or the last queued name has been compared, and
//   directly from idle when the queue is empty. Dequeue and peek on a
//   non-empty queue wait in S_READ for the registered RAM read; empty cases
//   and unused opcodes also finish directly from idle.
//   busy is high while a command is in progress and drops in the cycle that
//   done_o rises, so the next command may transfer in that cycle.
//   Reset empties the queue (head and count cleared); the name RAM is not
//   cleared, since only written slots are ever read.
// ----------------------------------------------------------------------------
`include "unique_name_fifo_defines.svh"

module unique_name_fifo
  import unf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  unf_req_t req_i,
  output logic     done_o,
  output unf_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_READ = 3'b100
  } unf_state_e;

  unf_state_e        state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [NAME_W-1:0] name_q, name_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  rd_off_q, rd_off_d;
  logic              done_q, done_d;
  unf_rsp_t          rsp_q, rsp_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [NAME_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [NAME_W-1:0] ram_rdata;
  logic [NAME_W-1:0] canon_name;

  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // keep bytes up to the first zero byte
  function automatic logic [NAME_W-1:0] canon(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              live;
    res  = '0;
    live = 1'b1;
    for (int b = 0; b < NAME_BYTES; b++) begin
      live = live & (raw[8*b +: 8] != 8'd0);
      if (live) begin
        res[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return res;
  endfunction

  unf_ram #(
    .WIDTH (NAME_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign canon_name = canon(req_i.name_in);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    name_d    = name_q;
    head_d    = head_q;
    count_d   = count_q;
    rd_off_d  = rd_off_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_raddr = head_q;
    ram_waddr = slot(head_q, count_q[IDX_W-1:0]);
    ram_wdata = name_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d            = req_i.opcode;
          name_d          = canon_name;
          rd_off_d        = '0;
          rsp_d.status    = ST_OK;
          rsp_d.name_out  = '0;
          rsp_d.occupancy = count_q;
          case (req_i.opcode) inside
            OP_ENQ: begin
              if (count_q == '0) begin
                ram_we          = 1'b1;
                ram_wdata       = canon_name;
                count_d         = CNT_W'(1);
                rsp_d.occupancy = CNT_W'(1);
                done_d          = 1'b1;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_DEQ, OP_PEEK: begin
              if (count_q == '0) begin
                rsp_d.status = ST_EMPTY;
                done_d       = 1'b1;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (ram_rdata == name_q) begin
          rsp_d.status = ST_DUP;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else if (CNT_W'(rd_off_q) + CNT_W'(1) == count_q) begin
          if (count_q == CNT_W'(QUEUE_DEPTH)) begin
            rsp_d.status = ST_FULL;
          end else begin
            ram_we          = 1'b1;
            count_d         = count_q + CNT_W'(1);
            rsp_d.occupancy = count_q + CNT_W'(1);
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          rd_off_d  = rd_off_q + IDX_W'(1);
          ram_raddr = slot(head_q, rd_off_q + IDX_W'(1));
        end
      end
      S_READ: begin
        rsp_d.status    = ST_OK;
        rsp_d.name_out  = ram_rdata;
        rsp_d.occupancy = count_q;
        if (op_q == OP_DEQ) begin
          head_d          = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
          count_d         = count_q - CNT_W'(1);
          rsp_d.occupancy = count_q - CNT_W'(1);
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    name_q   <= name_d;
    rd_off_q <= rd_off_d;
    rsp_q    <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `UNF_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "count beyond depth")
  `UNF_ASSERT_NOW(a_scan_in_range, state_q == S_SCAN, CNT_W'(rd_off_q) < count_q, "scan past tail")
  `UNF_ASSERT_NEXT(a_cmd_progress, start && !busy, busy || done_o, "command dropped")
  `UNF_ASSERT_NOW(a_empty_zero, done_o && rsp_o.status == ST_EMPTY, rsp_o.name_out == '0, "empty name")

endmodule

// ===== hdl/unf_ram.sv =====
// ----------------------------------------------------------------------------
// unf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module unf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
